// ----- rtl/fbs_pkg.sv -----
// Shared constants, types and a helper function for the framebuffer scanout block.
package fbs_pkg;

	// Widths fixed by the register map and the result fields.
	localparam int ADDR_W    = 32;
	localparam int DIM_W     = 11;
	localparam int MODE_W    = 3;
	localparam int STRIDE_W  = 13;
	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 2;

	// Default bound on width and height.
	localparam int MAX_DIM_DEF = 1024;

	// Pixel mode codes.
	localparam logic [MODE_W-1:0] MODE_GRAY8    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PALETTE8 = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RGB444   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RGB565   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RGB888   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_XRGB8888 = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd3;

	// Per-item result of the address walker.
	typedef struct packed {
		logic              pixel_valid;
		logic              frame_done;
		logic [ADDR_W-1:0] next_address;
	} fbs_step_t;

	// Scanline stride in bytes: the line is padded to whole 32-bit words.
	function automatic logic [STRIDE_W-1:0] stride_bytes(input logic [DIM_W-1:0] w,
			input logic [MODE_W-1:0] mode);
		logic [STRIDE_W-1:0] words;
		logic [STRIDE_W-1:0] w3;
		w3 = STRIDE_W'(w) + STRIDE_W'({w, 1'b0});
		case (mode)
			MODE_GRAY8, MODE_PALETTE8: words = (STRIDE_W'(w) + STRIDE_W'(3)) >> 2;
			MODE_RGB888:               words = (w3 + STRIDE_W'(3)) >> 2;
			MODE_XRGB8888:             words = STRIDE_W'(w);
			default:                   words = (STRIDE_W'(w) + STRIDE_W'(1)) >> 1;
		endcase
		return {words[STRIDE_W-3:0], 2'b00};
	endfunction

endpackage

// ----- rtl/fbs_convert.sv -----
// Pixel format conversion from a stored pixel word to 8-bit red, green and blue.
module fbs_convert (
	input  logic                         enable,
	input  logic [fbs_pkg::MODE_W-1:0]   mode,
	input  logic [31:0]                  raw_pixel,
	output logic [fbs_pkg::CHAN_W-1:0]   red,
	output logic [fbs_pkg::CHAN_W-1:0]   green,
	output logic [fbs_pkg::CHAN_W-1:0]   blue
);
	import fbs_pkg::*;

	// x*255/31 and x*255/63 as a multiply by a scaled reciprocal and a shift.
	localparam logic [23:0] Scale5 = 24'd8625630;   // 255 * ceil(2^20 / 31)
	localparam logic [24:0] Scale6 = 25'd16977135;  // 255 * ceil(2^22 / 63)

	logic [27:0] red5_prod;
	logic [27:0] blue5_prod;
	logic [30:0] green6_prod;

	assign red5_prod   = 28'(raw_pixel[15:11]) * 28'(Scale5);
	assign blue5_prod  = 28'(raw_pixel[4:0]) * 28'(Scale5);
	assign green6_prod = 31'(raw_pixel[10:5]) * 31'(Scale6);

	always_comb begin
		red   = '0;
		green = '0;
		blue  = '0;
		if (enable) begin
			case (mode)
				MODE_RGB565: begin
					red   = red5_prod[27:20];
					green = green6_prod[29:22];
					blue  = blue5_prod[27:20];
				end
				MODE_RGB444: begin
					red   = {raw_pixel[11:8], raw_pixel[11:8]};
					green = {raw_pixel[7:4], raw_pixel[7:4]};
					blue  = {raw_pixel[3:0], raw_pixel[3:0]};
				end
				MODE_GRAY8: begin
					red   = raw_pixel[7:0];
					green = raw_pixel[7:0];
					blue  = raw_pixel[7:0];
				end
				MODE_RGB888, MODE_XRGB8888: begin
					red   = raw_pixel[23:16];
					green = raw_pixel[15:8];
					blue  = raw_pixel[7:0];
				end
				default: begin
					red   = '0;
					green = '0;
					blue  = '0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/fbs_scan.sv -----
// Frame walker: column, line and scanline address state and the next fetch address.
module fbs_scan #(
	parameter int MAX_DIM = fbs_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          operation,
	input  logic [fbs_pkg::ADDR_W-1:0]    frame_base,
	input  logic [fbs_pkg::DIM_W-1:0]     frame_width,
	input  logic [fbs_pkg::DIM_W-1:0]     frame_height,
	input  logic [fbs_pkg::MODE_W-1:0]    pixel_mode,
	output fbs_pkg::fbs_step_t            result
);
	import fbs_pkg::*;

	localparam int CW = $clog2(MAX_DIM);
	localparam int XW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
	localparam int OW = CW + 2;

	logic [CW-1:0]       column_q;
	logic [CW-1:0]       line_q;
	logic [ADDR_W-1:0]   line_address_q;
	logic [STRIDE_W-1:0] line_stride_q;
	logic                scanning_q;

	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [XW-1:0]     col_inc;
	logic [XW-1:0]     line_inc;
	logic              line_end;
	logic              last_line;
	logic [CW-1:0]     col_nxt;
	logic [OW-1:0]     offset;
	logic [ADDR_W-1:0] next_line_addr;

	// Width and height saturate at the configured bound.
	always_comb begin
		w_eff = frame_width;
		h_eff = frame_height;
		if (XW'(frame_width) > XW'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end
		if (XW'(frame_height) > XW'(MAX_DIM)) begin
			h_eff = DIM_W'(MAX_DIM);
		end
	end

	assign col_inc   = XW'(column_q) + XW'(1);
	assign line_inc  = XW'(line_q) + XW'(1);
	assign line_end  = col_inc >= XW'(w_eff);
	assign last_line = line_inc >= XW'(h_eff);
	assign col_nxt   = line_end ? '0 : col_inc[CW-1:0];
	assign next_line_addr = line_address_q + ADDR_W'(line_stride_q);

	// Byte offset of the next pixel within its scanline.
	always_comb begin
		case (pixel_mode)
			MODE_GRAY8, MODE_PALETTE8: offset = OW'(col_nxt);
			MODE_RGB888:               offset = OW'({col_nxt, 1'b0}) + OW'(col_nxt);
			MODE_XRGB8888:             offset = OW'({col_nxt, 2'b00});
			default:                   offset = OW'({col_nxt, 1'b0});
		endcase
	end

	always_comb begin
		result = '0;
		if (!operation) begin
			result.next_address = frame_base;
		end else if (scanning_q) begin
			result.pixel_valid  = 1'b1;
			result.frame_done   = line_end && last_line;
			result.next_address = line_end ? next_line_addr
			                               : line_address_q + ADDR_W'(offset);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q       <= '0;
			line_q         <= '0;
			line_address_q <= '0;
			line_stride_q  <= '0;
			scanning_q     <= 1'b0;
		end else if (step) begin
			if (!operation) begin
				column_q       <= '0;
				line_q         <= '0;
				line_address_q <= frame_base;
				line_stride_q  <= stride_bytes(w_eff, pixel_mode);
				scanning_q     <= (w_eff != '0) && (h_eff != '0);
			end else if (scanning_q) begin
				column_q <= col_nxt;
				if (line_end) begin
					line_q         <= line_inc[CW-1:0];
					line_address_q <= next_line_addr;
					if (last_line) begin
						scanning_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/framebuffer_scanout_to_rgb888_top.sv -----
// Top level of the framebuffer scanout block: registers, pipeline stages and handshakes.
//
// The block walks one frame of a bitmap whose scanlines are padded to 32-bit words and
// converts each fetched pixel to RGB888. A transfer with operation 0 starts a frame and
// answers with next_address equal to frame_base; each following transfer with operation 1
// carries the pixel read at the last reported address and answers with its red, green and
// blue, pixel_valid, frame_done on the last pixel, and the byte address of the next pixel.
// Every input transfer yields exactly one result transfer. An item passes through the input
// register and then the result register, and a new item is taken every cycle as long as
// the result side keeps taking transfers; the fetch address and the color conversion are
// each one short combinational path between those two registers. Width and height saturate
// at MAX_DIM. Registers must be written by the user through cfg_write, cfg_index and cfg_data
// only while no transfer is in flight; the block itself does not enforce this.
module framebuffer_scanout_to_rgb888_top #(
	parameter int MAX_DIM = fbs_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [fbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbs_pkg::ADDR_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [31:0]                      raw_pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fbs_pkg::CHAN_W-1:0]       red,
	output logic [fbs_pkg::CHAN_W-1:0]       green,
	output logic [fbs_pkg::CHAN_W-1:0]       blue,
	output logic                             pixel_valid,
	output logic [fbs_pkg::ADDR_W-1:0]       next_address,
	output logic                             frame_done
);
	import fbs_pkg::*;

	// Configuration registers.
	logic [ADDR_W-1:0] frame_base_q;
	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic [MODE_W-1:0] pixel_mode_q;

	// Input stage.
	logic        valid_s1;
	logic        operation_s1;
	logic [31:0] raw_pixel_s1;

	// Result stage.
	logic              out_valid_q;
	logic [CHAN_W-1:0] red_q;
	logic [CHAN_W-1:0] green_q;
	logic [CHAN_W-1:0] blue_q;
	logic              pixel_valid_q;
	logic [ADDR_W-1:0] next_address_q;
	logic              frame_done_q;

	logic              advance;
	logic              step;
	fbs_step_t         scan_result;
	logic [CHAN_W-1:0] red_c;
	logic [CHAN_W-1:0] green_c;
	logic [CHAN_W-1:0] blue_c;

	// The result register frees up when it is empty or its transfer completes;
	// the input stage then moves forward and can take a new transfer in the same cycle.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q   <= '0;
			frame_width_q  <= DIM_W'(176);
			frame_height_q <= DIM_W'(208);
			pixel_mode_q   <= MODE_RGB565;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_BASE:   frame_base_q   <= cfg_data;
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				REG_PIXEL_MODE:   pixel_mode_q   <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_s1 <= operation;
			raw_pixel_s1 <= raw_pixel;
		end
	end

	fbs_scan #(
		.MAX_DIM(MAX_DIM)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.operation    (operation_s1),
		.frame_base   (frame_base_q),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pixel_mode   (pixel_mode_q),
		.result       (scan_result)
	);

	// Color channels are forced to zero unless the walker accepted a pixel.
	fbs_convert u_convert (
		.enable    (scan_result.pixel_valid),
		.mode      (pixel_mode_q),
		.raw_pixel (raw_pixel_s1),
		.red       (red_c),
		.green     (green_c),
		.blue      (blue_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			red_q          <= red_c;
			green_q        <= green_c;
			blue_q         <= blue_c;
			pixel_valid_q  <= scan_result.pixel_valid;
			next_address_q <= scan_result.next_address;
			frame_done_q   <= scan_result.frame_done;
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign pixel_valid  = pixel_valid_q;
	assign next_address = next_address_q;
	assign frame_done   = frame_done_q;

	// The end of a frame is only ever reported on a converted pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> pixel_valid_q)
		else $error("frame_done without a converted pixel");

	// A result that carries no pixel has black color channels.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pixel_valid_q |-> red_q == '0 && green_q == '0 && blue_q == '0)
		else $error("nonzero color on a result without a pixel");

	// The input side stalls only behind a full result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && valid_s1 && !out_ready)
		else $error("input stalled while the pipeline could advance");

endmodule

// ----- sim/tb_framebuffer_scanout_to_rgb888_top.sv -----
// Self-checking testbench for the framebuffer scanout block and its handshakes.
module tb_framebuffer_scanout_to_rgb888_top;
	import fbs_pkg::*;

	// Operation codes carried by the input transfer.
	localparam logic OP_START = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// The two mode codes that have no meaning and must convert to black.
	localparam logic [MODE_W-1:0] MODE_UNKNOWN_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNKNOWN_B = 3'd7;

	// Idle time after draining lets any late result show up.
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES    = 20;
	localparam int SINK_HOLD_CYCLES = 60;
	localparam int RANDOM_ITEMS  = 900;
	// The slowest legal run stays far below this: about 1100 transfers, each of
	// which could see the longest sender gap and the longest receiver stall.
	localparam int LIMIT_CYCLES  = 600000;

	// One result transfer as the block should present it.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              pixel_valid;
		logic [ADDR_W-1:0] next_address;
		logic              frame_done;
	} rgb_reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 operation;
	logic [31:0]          raw_pixel;
	logic                 out_valid;
	logic                 out_ready;
	logic [CHAN_W-1:0]    red;
	logic [CHAN_W-1:0]    green;
	logic [CHAN_W-1:0]    blue;
	logic                 pixel_valid;
	logic [ADDR_W-1:0]    next_address;
	logic                 frame_done;

	framebuffer_scanout_to_rgb888_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.raw_pixel    (raw_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.pixel_valid  (pixel_valid),
		.next_address (next_address),
		.frame_done   (frame_done)
	);

	// Our own copy of the register file, updated on every write we issue.
	logic [ADDR_W-1:0] reg_base;
	logic [DIM_W-1:0]  reg_width;
	logic [DIM_W-1:0]  reg_height;
	logic [MODE_W-1:0] reg_mode;

	// Our own copy of the scan position, mirrored transfer by transfer.
	int unsigned       scan_column;
	int unsigned       scan_line;
	logic [ADDR_W-1:0] scan_line_addr;
	int unsigned       scan_stride;
	bit                scan_active;

	// Results that accepted input transfers have caused but that have not come out yet.
	rgb_reply_t expected_replies[$];

	int unsigned error_count     = 0;
	int unsigned items_sent      = 0;
	int unsigned useful_items    = 0;
	int unsigned results_checked = 0;
	int unsigned frames_finished = 0;
	int unsigned cycle_count     = 0;

	// Pacing controls shared by the sender, the receiver and the test tasks.
	bit steady_flow   = 1'b0;
	bit sink_hold_req = 1'b0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] dim);
		return (dim > MAX_DIM_DEF) ? MAX_DIM_DEF : dim;
	endfunction

	// Bytes fetched per pixel; unknown modes walk like 16-bit pixels.
	function automatic int unsigned fetch_bytes(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_GRAY8, MODE_PALETTE8: return 1;
			MODE_RGB444, MODE_RGB565:  return 2;
			MODE_RGB888:               return 3;
			MODE_XRGB8888:             return 4;
			default:                   return 2;
		endcase
	endfunction

	// Works out the result of one input transfer and advances the mirrored scan state.
	function automatic rgb_reply_t predict_reply(input logic op, input logic [31:0] pix);
		rgb_reply_t  reply;
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned nbytes;
		reply  = '0;
		w_eff  = clamp_dim(reg_width);
		h_eff  = clamp_dim(reg_height);
		nbytes = fetch_bytes(reg_mode);
		if (op == OP_START) begin
			// Scanlines are padded to whole 32-bit words; the stride is frozen here.
			scan_stride    = ((w_eff * nbytes * 8 + 31) / 32) * 4;
			scan_line_addr = reg_base;
			scan_column    = 0;
			scan_line      = 0;
			scan_active    = (w_eff != 0) && (h_eff != 0);
			reply.next_address = reg_base;
			return reply;
		end
		// A pixel outside a frame is dropped and answered with all zeros.
		if (!scan_active)
			return reply;
		case (reg_mode)
			MODE_RGB565: begin
				reply.red   = CHAN_W'(((pix >> 11) & 32'h1f) * 255 / 31);
				reply.green = CHAN_W'(((pix >> 5) & 32'h3f) * 255 / 63);
				reply.blue  = CHAN_W'((pix & 32'h1f) * 255 / 31);
			end
			MODE_RGB444: begin
				reply.red   = CHAN_W'(((pix >> 8) & 32'hf) * 17);
				reply.green = CHAN_W'(((pix >> 4) & 32'hf) * 17);
				reply.blue  = CHAN_W'((pix & 32'hf) * 17);
			end
			MODE_GRAY8: begin
				reply.red   = pix[7:0];
				reply.green = pix[7:0];
				reply.blue  = pix[7:0];
			end
			MODE_RGB888, MODE_XRGB8888: begin
				reply.red   = pix[23:16];
				reply.green = pix[15:8];
				reply.blue  = pix[7:0];
			end
			default: ;
		endcase
		reply.pixel_valid = 1'b1;
		// Bounds are compared with ">=" so that a bound lowered mid-frame ends the line.
		scan_column++;
		if (scan_column >= w_eff) begin
			scan_column    = 0;
			scan_line++;
			scan_line_addr = scan_line_addr + ADDR_W'(scan_stride);
			if (scan_line >= h_eff) begin
				scan_active      = 1'b0;
				reply.frame_done = 1'b1;
			end
		end
		reply.next_address = scan_line_addr + ADDR_W'(scan_column * nbytes);
		return reply;
	endfunction

	// Idle stretches: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 88)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	// Frame sizes: mostly tiny so frames finish, sometimes zero, at the bound or past it.
	function automatic logic [DIM_W-1:0] pick_dim(input int unsigned usual_max);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return DIM_W'($urandom_range(1, usual_max));
		else if (roll < 92)
			return DIM_W'($urandom_range(usual_max + 1, 40));
		else if (roll < 95)
			return '0;
		else if (roll < 98)
			return DIM_W'(MAX_DIM_DEF);
		else
			return '1;
	endfunction

	// Writes one register while no transfer is in flight and mirrors it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		case (idx)
			REG_FRAME_BASE:   reg_base   = value;
			REG_FRAME_WIDTH:  reg_width  = value[DIM_W-1:0];
			REG_FRAME_HEIGHT: reg_height = value[DIM_W-1:0];
			REG_PIXEL_MODE:   reg_mode   = value[MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Offers one input item, waits for its transfer and records what it should cause.
	// Valid stays high on return, so back-to-back items keep it asserted.
	task automatic send_item(input logic op, input logic [31:0] pix);
		int unsigned gap;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  = 1'b1;
		operation = op;
		raw_pixel = pix;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (op == OP_START || scan_active)
			useful_items++;
		expected_replies.push_back(predict_reply(op, pix));
	endtask

	task automatic send_pixels(input int unsigned count);
		repeat (count) send_item(OP_PIXEL, $urandom);
	endtask

	// Lets everything in flight come out; registers may be written afterwards.
	task automatic drain_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Receiver side: every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin : check_replies
		rgb_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: result transfer with nothing expected, next_address 0x%0h",
					$time, next_address);
				error_count++;
			end else begin
				want = expected_replies.pop_front();
				compare_field("red", 32'(want.red), 32'(red));
				compare_field("green", 32'(want.green), 32'(green));
				compare_field("blue", 32'(want.blue), 32'(blue));
				compare_field("pixel_valid", 32'(want.pixel_valid), 32'(pixel_valid));
				compare_field("next_address", want.next_address, next_address);
				compare_field("frame_done", 32'(want.frame_done), 32'(frame_done));
				results_checked++;
				if (frame_done)
					frames_finished++;
			end
		end
	end

	// Receiver pacing. A hold request from a test task takes priority and is
	// timed here, while the sender keeps pushing and the block backs up.
	initial begin : sink_pacing
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				out_ready = 1'b1;
			end else if (steady_flow) begin
				out_ready = 1'b1;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
				out_ready = 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// Right after reset: a stray pixel is ignored, then a frame starts with the
	// power-on geometry and RGB565, fed with all-zero, all-one and magenta words.
	task automatic test_reset_defaults();
		send_item(OP_PIXEL, 32'hFFFF_FFFF);
		send_item(OP_START, 32'h0000_0000);
		send_item(OP_PIXEL, 32'h0000_0000);
		send_item(OP_PIXEL, 32'hFFFF_FFFF);
		send_item(OP_PIXEL, 32'h0000_F81F);
		drain_replies();
	endtask

	// One single-pixel frame per mode, unknown codes included.
	task automatic test_every_mode();
		logic [MODE_W-1:0] all_modes [8] = '{MODE_GRAY8, MODE_PALETTE8, MODE_RGB444,
			MODE_RGB565, MODE_RGB888, MODE_XRGB8888, MODE_UNKNOWN_A, MODE_UNKNOWN_B};
		write_reg(REG_FRAME_WIDTH, ADDR_W'(1));
		write_reg(REG_FRAME_HEIGHT, ADDR_W'(1));
		write_reg(REG_FRAME_BASE, 32'h1000_0000);
		foreach (all_modes[i]) begin
			write_reg(REG_PIXEL_MODE, ADDR_W'(all_modes[i]));
			send_item(OP_START, 32'h0000_0000);
			send_item(OP_PIXEL, (i % 2 == 0) ? 32'hFFFF_FFFF : $urandom);
			drain_replies();
		end
	endtask

	// A zero width or a zero height leaves the block idle, so the pixel after it is dropped.
	task automatic test_zero_sizes();
		write_reg(REG_FRAME_WIDTH, ADDR_W'(0));
		write_reg(REG_FRAME_HEIGHT, ADDR_W'(3));
		send_item(OP_START, 32'h0000_0000);
		send_item(OP_PIXEL, 32'h1234_5678);
		drain_replies();
		write_reg(REG_FRAME_WIDTH, ADDR_W'(5));
		write_reg(REG_FRAME_HEIGHT, ADDR_W'(0));
		send_item(OP_START, 32'h0000_0000);
		send_item(OP_PIXEL, 32'h8765_4321);
		drain_replies();
	endtask

	// Oversized geometry saturates, the address wraps past the top of memory, and
	// shrinking width and height mid-frame ends the frame at the next pixel while
	// the stride latched at start still applies.
	task automatic test_saturation_and_wrap();
		write_reg(REG_FRAME_BASE, 32'hFFFF_FFF8);
		write_reg(REG_FRAME_WIDTH, ADDR_W'({DIM_W{1'b1}}));
		write_reg(REG_FRAME_HEIGHT, ADDR_W'({DIM_W{1'b1}}));
		write_reg(REG_PIXEL_MODE, ADDR_W'(MODE_XRGB8888));
		send_item(OP_START, 32'h0000_0000);
		send_pixels(2);
		drain_replies();
		write_reg(REG_FRAME_WIDTH, ADDR_W'(2));
		write_reg(REG_FRAME_HEIGHT, ADDR_W'(1));
		write_reg(REG_PIXEL_MODE, ADDR_W'(MODE_GRAY8));
		send_item(OP_PIXEL, 32'h0000_00A5);
		drain_replies();
	endtask

	// The receiver stops for a long stretch while a full frame is offered back to back.
	task automatic test_backpressure();
		write_reg(REG_FRAME_BASE, 32'h0040_0000);
		write_reg(REG_FRAME_WIDTH, ADDR_W'(4));
		write_reg(REG_FRAME_HEIGHT, ADDR_W'(3));
		write_reg(REG_PIXEL_MODE, ADDR_W'(MODE_RGB888));
		steady_flow   = 1'b1;
		sink_hold_req = 1'b1;
		send_item(OP_START, 32'h0000_0000);
		send_pixels(12);
		drain_replies();
		steady_flow = 1'b0;
	endtask

	// Random frames: mostly complete well-formed frames with random pixel words,
	// the rest cut short, resized mid-frame or followed by stray pixels.
	task automatic test_random_frames();
		int unsigned goal;
		int unsigned total;
		int unsigned count;
		int unsigned style;
		int unsigned roll;
		goal = useful_items + RANDOM_ITEMS;
		while (useful_items < goal) begin
			drain_replies();
			steady_flow = ($urandom_range(0, 5) == 0);
			roll = $urandom_range(0, 9);
			if (roll == 0)
				write_reg(REG_FRAME_BASE, 32'h0000_0000);
			else if (roll == 1)
				write_reg(REG_FRAME_BASE, 32'hFFFF_FFFF - $urandom_range(0, 64));
			else if (roll < 6)
				write_reg(REG_FRAME_BASE, $urandom);
			write_reg(REG_FRAME_WIDTH, ADDR_W'(pick_dim(6)));
			write_reg(REG_FRAME_HEIGHT, ADDR_W'(pick_dim(4)));
			write_reg(REG_PIXEL_MODE, ADDR_W'($urandom_range(0, 7)));
			send_item(OP_START, $urandom);
			total = clamp_dim(reg_width) * clamp_dim(reg_height);
			style = $urandom_range(0, 9);
			if (total == 0)
				count = $urandom_range(1, 2);
			else if (total > 48 || style == 0)
				count = $urandom_range(1, (total < 30) ? total : 30);
			else
				count = total;
			if (style == 1 && count > 1) begin
				send_pixels(count / 2);
				drain_replies();
				write_reg(REG_FRAME_WIDTH, ADDR_W'($urandom_range(1, 6)));
				write_reg(REG_FRAME_HEIGHT, ADDR_W'($urandom_range(1, 4)));
				write_reg(REG_PIXEL_MODE, ADDR_W'($urandom_range(0, 7)));
				send_pixels($urandom_range(1, 8));
			end else begin
				send_pixels(count);
			end
			if (style == 2)
				send_pixels($urandom_range(1, 2));
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_FRAME_BASE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		operation = OP_START;
		raw_pixel = '0;
		// Register values after reset, mirrored for the predictor.
		reg_base       = '0;
		reg_width      = DIM_W'(176);
		reg_height     = DIM_W'(208);
		reg_mode       = MODE_RGB565;
		scan_column    = 0;
		scan_line      = 0;
		scan_line_addr = '0;
		scan_stride    = 0;
		scan_active    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_every_mode();
		test_zero_sizes();
		test_saturation_and_wrap();
		test_backpressure();
		test_random_frames();

		drain_replies();
		repeat (END_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_replies.size());
			error_count++;
		end
		$display("Sent %0d input transfers (%0d acted on), checked %0d results, %0d frames done.",
			items_sent, useful_items, results_checked, frames_finished);
		$display("Covered all eight mode codes, zero and saturated sizes, address wrap, "
			, "mid-frame resizing and a long receiver stall.");
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
